### hw/rtl/brd_pkg.sv
// ----------------------------------------------------------------------------
// brd_pkg
// Shared constants, command codes and control structs for the ring deque.
// ----------------------------------------------------------------------------
package brd_pkg;

	localparam int DATA_W        = 32;
	localparam int CMD_W         = 3;
	localparam int CAP_W         = 5;
	localparam int ADDR_W        = 3;
	localparam int MAX_SLOTS_DEF = 16;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	// command codes
	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = CMD_W'(0);
	localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = CMD_W'(1);
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = CMD_W'(2);
	localparam logic [CMD_W-1:0] CMD_POP_REAR   = CMD_W'(3);
	localparam logic [CMD_W-1:0] CMD_STATUS     = CMD_W'(4);

	// register index (paddr above the byte offset)
	localparam logic [ADDR_W-3:0] REG_CAPACITY = '0;

	// controller to datapath
	typedef struct packed {
		logic exec;   // apply the incoming word to the ring
		logic load;   // capture the result into the output register
	} brd_cmd_t;

	// register block to datapath
	typedef struct packed {
		logic             wr;    // capacity written this cycle: empty the ring
		logic [CAP_W-1:0] cap;   // value being written
	} brd_cfg_t;

endpackage

### hw/rtl/bounded_ring_deque.sv
// A result passes through the S_RD and S_LD states after its command word is
// accepted. A new command word is taken only in S_IDLE, after the write of the
// slot RAM and its registered read of the new front and rear slots.
// A finished result waits in the output register while the next word is taken.
// Reset: capacity 16, deque empty; slot RAM is not cleared (no clearing pass).
// ----------------------------------------------------------------------------
// bounded_ring_deque
// Double-ended queue of signed words in a ring with programmable capacity.
// ----------------------------------------------------------------------------
module bounded_ring_deque import brd_pkg::*; #(
	parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [CMD_W-1:0]         command,
	input  logic signed [DATA_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     ok,
	output logic signed [DATA_W-1:0] front_value,
	output logic signed [DATA_W-1:0] rear_value,
	output logic                     is_empty,
	output logic                     is_full,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_W-1:0]        paddr,
	input  logic [DATA_W-1:0]        pwdata,
	output logic [DATA_W-1:0]        prdata,
	output logic                     pready
);

	brd_cmd_t         cmd;
	brd_cfg_t         cfg;
	logic [CAP_W-1:0] capacity;

	brd_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.capacity (capacity),
		.cfg      (cfg)
	);

	brd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	brd_dp #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg         (cfg),
		.capacity    (capacity),
		.command     (command),
		.value       (value),
		.ok          (ok),
		.front_value (front_value),
		.rear_value  (rear_value),
		.is_empty    (is_empty),
		.is_full     (is_full)
	);

endmodule

### hw/rtl/brd_ram.sv
// ----------------------------------------------------------------------------
// brd_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module brd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

### hw/rtl/brd_regs.sv
// ----------------------------------------------------------------------------
// brd_regs
// APB register block: holds the capacity register.
// ----------------------------------------------------------------------------
module brd_regs import brd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output logic [CAP_W-1:0]  capacity,
	output brd_cfg_t          cfg
);

	logic [CAP_W-1:0] capacity_q;
	logic             hit_cap;

	assign hit_cap = (paddr[ADDR_W-1:2] == REG_CAPACITY);

	assign pready  = 1'b1;
	assign cfg.wr  = psel && penable && pwrite && hit_cap;
	assign cfg.cap = pwdata[CAP_W-1:0];
	assign prdata  = hit_cap ? {{(DATA_W-CAP_W){1'b0}}, capacity_q} : '0;
	assign capacity = capacity_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg.wr) begin
			capacity_q <= cfg.cap;
		end
	end

endmodule

### hw/rtl/brd_ctrl.sv
// ----------------------------------------------------------------------------
// brd_ctrl
// Sequencer: accept a word, wait out the RAM read, load the result register.
// ----------------------------------------------------------------------------
module brd_ctrl import brd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	output brd_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_RD,
		S_LD
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign cmd.exec  = in_valid && (state_q == S_IDLE);
	// result register is free when empty or being drained this cycle
	assign cmd.load  = (state_q == S_LD) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.exec) state_q <= S_RD;
				end
				S_RD: begin
					state_q <= S_LD;
				end
				S_LD: begin
					if (cmd.load) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTH
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after accepting a word");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (!out_valid || !out_stall))
		else $error("pending result overwritten");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LD && !out_valid) |=> (out_valid && !in_stall))
		else $error("result not delivered with free output register");
`endif

endmodule

### hw/rtl/brd_dp.sv
// ----------------------------------------------------------------------------
// brd_dp
// Ring datapath: front/rear gap indices, count, slot RAM and result register.
// ----------------------------------------------------------------------------
module brd_dp import brd_pkg::*; #(
	parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  brd_cmd_t                 cmd,
	input  brd_cfg_t                 cfg,
	input  logic [CAP_W-1:0]         capacity,
	input  logic [CMD_W-1:0]         command,
	input  logic signed [DATA_W-1:0] value,
	output logic                     ok,
	output logic signed [DATA_W-1:0] front_value,
	output logic signed [DATA_W-1:0] rear_value,
	output logic                     is_empty,
	output logic                     is_full
);

	localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CW    = ((IDX_W > CAP_W) ? IDX_W : CAP_W) + 1;

	// capacity clamped to 1..MAX_SLOTS
	function automatic logic [CW-1:0] eff_cap(input logic [CAP_W-1:0] c);
		logic [CW-1:0] e;
		e = CW'(c);
		if (e == '0) e = CW'(1);
		if (e > CW'(MAX_SLOTS)) e = CW'(MAX_SLOTS);
		return e;
	endfunction

	function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] i,
	                                              input logic [CW-1:0] cap);
		logic [CW-1:0] n;
		n = CW'(i) + CW'(1);
		return (n >= cap) ? '0 : IDX_W'(n);
	endfunction

	function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] i,
	                                              input logic [CW-1:0] cap);
		return (i == '0) ? IDX_W'(cap - CW'(1)) : i - IDX_W'(1);
	endfunction

	logic [IDX_W-1:0]  front_q, rear_q, front_d, rear_d;
	logic [CAP_W-1:0]  count_q, count_d;
	logic              ok_q, ok_d;
	logic [CW-1:0]     cap_eff;
	logic              full, empty;
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [DATA_W-1:0] rdata_a, rdata_b;

	assign cap_eff = eff_cap(capacity);
	assign full    = (CW'(count_q) >= cap_eff);
	assign empty   = (count_q == '0);

	always_comb begin
		front_d   = front_q;
		rear_d    = rear_q;
		count_d   = count_q;
		ok_d      = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = front_q;
		case (command)
			CMD_PUSH_FRONT: begin
				if (!full) begin
					ram_we  = cmd.exec;
					front_d = ring_dec(front_q, cap_eff);
					count_d = count_q + CAP_W'(1);
					ok_d    = 1'b1;
				end
			end
			CMD_PUSH_REAR: begin
				if (!full) begin
					ram_we    = cmd.exec;
					ram_waddr = rear_q;
					rear_d    = ring_inc(rear_q, cap_eff);
					count_d   = count_q + CAP_W'(1);
					ok_d      = 1'b1;
				end
			end
			CMD_POP_FRONT: begin
				if (!empty) begin
					front_d = ring_inc(front_q, cap_eff);
					count_d = count_q - CAP_W'(1);
					ok_d    = 1'b1;
				end
			end
			CMD_POP_REAR: begin
				if (!empty) begin
					rear_d  = ring_dec(rear_q, cap_eff);
					count_d = count_q - CAP_W'(1);
					ok_d    = 1'b1;
				end
			end
			CMD_STATUS: begin
				ok_d = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			rear_q  <= IDX_W'(MAX_SLOTS > 1);
			count_q <= '0;
			ok_q    <= 1'b0;
		end else if (cfg.wr) begin
			// rear gap restarts at 1 mod capacity
			front_q <= '0;
			rear_q  <= (eff_cap(cfg.cap) == CW'(1)) ? '0 : IDX_W'(1);
			count_q <= '0;
		end else if (cmd.exec) begin
			front_q <= front_d;
			rear_q  <= rear_d;
			count_q <= count_d;
			ok_q    <= ok_d;
		end
	end

	// read ports follow the current gaps; read data is registered
	brd_ram #(
		.WIDTH (DATA_W),
		.DEPTH (MAX_SLOTS)
	) u_slots (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (value),
		.raddr_a (ring_inc(front_q, cap_eff)),
		.raddr_b (ring_dec(rear_q, cap_eff)),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ok          <= ok_q;
			front_value <= empty ? '1 : rdata_a;
			rear_value  <= empty ? '1 : rdata_b;
			is_empty    <= empty;
			is_full     <= full;
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(count_q) <= cap_eff)
		else $error("count above capacity");

	a_front_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(front_q) < cap_eff && CW'(rear_q) < cap_eff)
		else $error("gap index outside ring");

	a_write_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (CW'(ram_waddr) < cap_eff && !full))
		else $error("slot write outside ring or into full deque");
`endif

endmodule
